// ----- sv/json_string_unescape_utf8_top_defines.svh -----
// Assertion macros for the JSON string unescaper.
// Each macro expects clk and rst in scope at the point of use.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define JSU_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- sv/jsu_pkg.sv -----
`default_nettype none
package jsu_pkg;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CTRL_LIMIT   = 8'h20;

  // Surrogate ranges and UTF-8 length limits
  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;
  localparam logic [20:0] ONE_BYTE_MAX  = 21'h7F;
  localparam logic [20:0] TWO_BYTE_MAX  = 21'h7FF;
  localparam logic [20:0] THREE_BYTE_MAX = 21'hFFFF;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_NO_QUOTE   = 4'd1,
    ERR_CONTROL    = 4'd2,
    ERR_BAD_ESCAPE = 4'd3,
    ERR_ESC_END    = 4'd4,
    ERR_HEX_CUT    = 4'd5,
    ERR_NON_HEX    = 4'd6,
    ERR_NO_LOW     = 4'd7,
    ERR_BAD_LOW    = 4'd8,
    ERR_LONE_LOW   = 4'd9,
    ERR_UNCLOSED   = 4'd10
  } err_t;

  // One decoded job: one to four results caused by one text byte
  typedef struct packed {
    logic [1:0]      cnt_m1;  // result count minus one
    logic            data;    // results carry decoded bytes
    logic            done;    // closing quote seen
    err_t            err;
    logic [3:0][7:0] octets;  // octets[0] goes out first
  } job_t;

  function automatic job_t mk_byte(input logic [7:0] b);
    job_t j;
    j = '0;
    j.data = 1'b1;
    j.err = ERR_NONE;
    j.octets[0] = b;
    return j;
  endfunction

  function automatic job_t mk_error(input err_t e);
    job_t j;
    j = '0;
    j.err = e;
    return j;
  endfunction

  function automatic job_t mk_done();
    job_t j;
    j = '0;
    j.done = 1'b1;
    j.err = ERR_NONE;
    return j;
  endfunction

  // Hex digit decode: bit 4 flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Encode one code point as UTF-8
  function automatic job_t encode_cp(input logic [20:0] cp);
    job_t j;
    j = '0;
    j.data = 1'b1;
    j.err = ERR_NONE;
    if (cp <= ONE_BYTE_MAX) begin
      j.cnt_m1 = 2'd0;
      j.octets[0] = cp[7:0];
    end else if (cp <= TWO_BYTE_MAX) begin
      j.cnt_m1 = 2'd1;
      j.octets[0] = {3'b110, cp[10:6]};
      j.octets[1] = {2'b10, cp[5:0]};
    end else if (cp <= THREE_BYTE_MAX) begin
      j.cnt_m1 = 2'd2;
      j.octets[0] = {4'b1110, cp[15:12]};
      j.octets[1] = {2'b10, cp[11:6]};
      j.octets[2] = {2'b10, cp[5:0]};
    end else begin
      j.cnt_m1 = 2'd3;
      j.octets[0] = {5'b11110, cp[20:18]};
      j.octets[1] = {2'b10, cp[17:12]};
      j.octets[2] = {2'b10, cp[11:6]};
      j.octets[3] = {2'b10, cp[5:0]};
    end
    return j;
  endfunction

endpackage
`default_nettype wire

// ----- sv/json_string_unescape_utf8_top.sv -----
// Channel   Handshake                 Payload
// text      text_valid / text_stall   text_byte, text_end
// result    res_valid  / res_stall    out_byte, out_valid, string_done, error_code, last
//
// One text byte is taken per cycle while the job queue is not full; its job is registered
// in the queue, then in the back. The result side moves one result per cycle while
// res_stall is low, so a \u escape that yields k UTF-8 bytes makes k results; the job
// queue (QUEUE_DEPTH entries) absorbs it. text_stall rises only when the job queue is full.
// Synchronous active-high reset returns the parser to awaiting a quote and empties the queue.
`default_nettype none
`include "json_string_unescape_utf8_top_defines.svh"
module json_string_unescape_utf8_top #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       text_valid,
  output logic            text_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       text_end,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            string_done,
  output logic [3:0]      error_code,
  output logic            last
);

  jsu_pkg::job_t push_job, head_job;
  logic          push, pop, q_full, q_not_empty;
  logic          res_err;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_byte  (text_byte),
    .text_end   (text_end),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .head_job  (head_job),
    .not_empty (q_not_empty)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .out_byte    (out_byte),
    .out_valid   (out_valid),
    .string_done (string_done),
    .error_code  (error_code),
    .last        (last)
  );

  assign res_err = (error_code != jsu_pkg::ERR_NONE);

  // Error results stand alone and carry no byte
  `JSU_ASSERT_IMPLY(a_err_alone, res_valid && res_err, !out_valid && last)
  // Done results stand alone, error-free and byte-free
  `JSU_ASSERT_IMPLY(a_done_alone, res_valid && string_done, last && !out_valid && !res_err)
  // A multi-byte sequence continues without a gap
  `JSU_ASSERT_NEXT(a_seq_gapless, res_valid && !res_stall && !last, res_valid && out_valid)

endmodule
`default_nettype wire

// ----- sv/jsu_front.sv -----
`default_nettype none
// Front: parse a byte per cycle unless q_full, emit jobs
module jsu_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           text_valid,
  output logic                text_stall,
  input  wire logic [7:0]     text_byte,
  input  wire logic           text_end,
  input  wire logic           q_full,
  output logic                push,
  output jsu_pkg::job_t       push_job
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_STR, PH_ESC, PH_HEX1, PH_PAIR_BS, PH_PAIR_U, PH_HEX2, PH_SKIP
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [9:0]  high_half, high_half_next;
  logic        job_v;
  logic        accept;

  assign text_stall = q_full;
  assign accept     = text_valid && !q_full;
  assign push       = accept && job_v;

  // Classify the byte against the current phase
  always_comb begin
    logic [4:0]  digit;
    logic [15:0] acc;
    phase_next     = phase;
    hex_accum_next = hex_accum;
    hex_count_next = hex_count;
    high_half_next = high_half;
    job_v          = 1'b0;
    push_job       = '0;
    digit          = jsu_pkg::hex_digit(text_byte);
    acc            = {hex_accum[11:0], digit[3:0]};
    case (phase)
      PH_IDLE: begin
        if (!text_end) begin
          if (text_byte != jsu_pkg::CH_QUOTE) begin
            job_v = 1'b1;
            push_job = jsu_pkg::mk_error(jsu_pkg::ERR_NO_QUOTE);
            phase_next = PH_SKIP;
          end else begin
            phase_next = PH_STR;
          end
        end
      end
      PH_STR: begin
        job_v = 1'b1;
        if (text_end) begin
          push_job = jsu_pkg::mk_error(jsu_pkg::ERR_UNCLOSED);
          phase_next = PH_IDLE;
        end else if (text_byte == jsu_pkg::CH_QUOTE) begin
          push_job = jsu_pkg::mk_done();
          phase_next = PH_IDLE;
        end else if (text_byte < jsu_pkg::CTRL_LIMIT) begin
          push_job = jsu_pkg::mk_error(jsu_pkg::ERR_CONTROL);
          phase_next = PH_SKIP;
        end else if (text_byte == jsu_pkg::CH_BACKSLASH) begin
          job_v = 1'b0;
          phase_next = PH_ESC;
        end else begin
          push_job = jsu_pkg::mk_byte(text_byte);
        end
      end
      PH_ESC: begin
        job_v = 1'b1;
        if (text_end) begin
          push_job = jsu_pkg::mk_error(jsu_pkg::ERR_ESC_END);
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_STR;
          case (text_byte)
            jsu_pkg::CH_QUOTE,
            jsu_pkg::CH_BACKSLASH,
            jsu_pkg::CH_SLASH:   push_job = jsu_pkg::mk_byte(text_byte);
            jsu_pkg::CH_LOWER_B: push_job = jsu_pkg::mk_byte(8'h08);
            jsu_pkg::CH_LOWER_F: push_job = jsu_pkg::mk_byte(8'h0C);
            jsu_pkg::CH_LOWER_N: push_job = jsu_pkg::mk_byte(8'h0A);
            jsu_pkg::CH_LOWER_R: push_job = jsu_pkg::mk_byte(8'h0D);
            jsu_pkg::CH_LOWER_T: push_job = jsu_pkg::mk_byte(8'h09);
            jsu_pkg::CH_LOWER_U: begin
              job_v = 1'b0;
              phase_next = PH_HEX1;
              hex_accum_next = '0;
              hex_count_next = '0;
            end
            default: begin
              push_job = jsu_pkg::mk_error(jsu_pkg::ERR_BAD_ESCAPE);
              phase_next = PH_SKIP;
            end
          endcase
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (text_end) begin
          job_v = 1'b1;
          push_job = jsu_pkg::mk_error(jsu_pkg::ERR_HEX_CUT);
          phase_next = PH_IDLE;
        end else if (!digit[4]) begin
          job_v = 1'b1;
          push_job = jsu_pkg::mk_error(jsu_pkg::ERR_NON_HEX);
          phase_next = PH_SKIP;
        end else begin
          hex_accum_next = acc;
          if (hex_count != 2'd3) begin
            hex_count_next = hex_count + 2'd1;
          end else begin
            hex_count_next = '0;
            // Fourth digit: the code unit is complete
            if (phase == PH_HEX1) begin
              if (acc >= jsu_pkg::HIGH_SURR_MIN && acc <= jsu_pkg::HIGH_SURR_MAX) begin
                high_half_next = acc[9:0];
                phase_next = PH_PAIR_BS;
              end else if (acc >= jsu_pkg::LOW_SURR_MIN && acc <= jsu_pkg::LOW_SURR_MAX) begin
                job_v = 1'b1;
                push_job = jsu_pkg::mk_error(jsu_pkg::ERR_LONE_LOW);
                phase_next = PH_SKIP;
              end else begin
                job_v = 1'b1;
                push_job = jsu_pkg::encode_cp({5'd0, acc});
                phase_next = PH_STR;
              end
            end else begin
              job_v = 1'b1;
              if (acc < jsu_pkg::LOW_SURR_MIN || acc > jsu_pkg::LOW_SURR_MAX) begin
                push_job = jsu_pkg::mk_error(jsu_pkg::ERR_BAD_LOW);
                phase_next = PH_SKIP;
              end else begin
                push_job = jsu_pkg::encode_cp(
                  jsu_pkg::SUPP_BASE + {1'b0, high_half, acc[9:0]});
                phase_next = PH_STR;
              end
            end
          end
        end
      end
      PH_PAIR_BS, PH_PAIR_U: begin
        if (text_end) begin
          job_v = 1'b1;
          push_job = jsu_pkg::mk_error(jsu_pkg::ERR_NO_LOW);
          phase_next = PH_IDLE;
        end else if (phase == PH_PAIR_BS && text_byte == jsu_pkg::CH_BACKSLASH) begin
          phase_next = PH_PAIR_U;
        end else if (phase == PH_PAIR_U && text_byte == jsu_pkg::CH_LOWER_U) begin
          phase_next = PH_HEX2;
          hex_accum_next = '0;
          hex_count_next = '0;
        end else begin
          job_v = 1'b1;
          push_job = jsu_pkg::mk_error(jsu_pkg::ERR_NO_LOW);
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (text_end) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Advance parse state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      hex_accum <= '0;
      hex_count <= '0;
      high_half <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      hex_accum <= hex_accum_next;
      hex_count <= hex_count_next;
      high_half <= high_half_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/jsu_queue.sv -----
`default_nettype none
// Small job queue between front and back
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire jsu_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output jsu_pkg::job_t      head_job,
  output logic               not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::job_t  slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head_job  = slots[rd_ptr];

  // Hold pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ----- sv/jsu_back.sv -----
`default_nettype none
// Back: each job, a result per unstalled cycle
module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire jsu_pkg::job_t head_job,
  input  wire logic          q_not_empty,
  output logic               pop,
  output logic               res_valid,
  input  wire logic          res_stall,
  output logic [7:0]         out_byte,
  output logic               out_valid,
  output logic               string_done,
  output logic [3:0]         error_code,
  output logic               last
);

  jsu_pkg::job_t job;
  logic          busy;
  logic [1:0]    idx;
  logic          xfer;

  assign xfer = busy && !res_stall;
  assign last = (idx == job.cnt_m1);
  assign pop  = q_not_empty && (!busy || (xfer && last));

  assign res_valid   = busy;
  assign out_byte    = job.octets[idx];
  assign out_valid   = job.data;
  assign string_done = job.done;
  assign error_code  = job.err;

  // Load next job or step to the next result
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head_job;
    end
  end

endmodule
`default_nettype wire

// ----- tb/json_string_unescape_utf8_top_checker.sv -----
module json_string_unescape_utf8_top_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       text_valid,
  input  wire logic       text_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       text_end,
  input  wire logic       res_valid,
  input  wire logic       res_stall,
  input  wire logic [7:0] out_byte,
  input  wire logic       out_valid,
  input  wire logic       string_done,
  input  wire logic [3:0] error_code,
  input  wire logic       last,
  output int              mismatch_count,
  output int              results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // Bytes that the single-letter escapes stand for
  localparam logic [7:0] BACKSPACE    = 8'h08;
  localparam logic [7:0] FORM_FEED    = 8'h0C;
  localparam logic [7:0] LINE_FEED    = 8'h0A;
  localparam logic [7:0] CARRIAGE_RET = 8'h0D;
  localparam logic [7:0] HTAB         = 8'h09;

  typedef enum logic [2:0] {
    AWAIT_QUOTE,
    IN_STRING,
    AFTER_BACKSLASH,
    UNIT_HEX,
    PAIR_BACKSLASH,
    PAIR_U,
    LOW_HEX,
    SKIP_TO_END
  } scan_state_t;

  typedef struct {
    logic [7:0]    octet;
    logic          octet_valid;
    logic          done;
    jsu_pkg::err_t err;
    logic          last;
  } utf8_result_t;

  utf8_result_t decoded_q[$];
  scan_state_t  scan_state;
  logic [15:0]  unit_accum;
  logic [1:0]   digit_count;
  logic [9:0]   high_bits;
  int           miss_total = 0;
  int           pending_n = 0;

  assign mismatch_count      = miss_total;
  assign results_outstanding = pending_n;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic push_result(input logic [7:0] b, input logic v, input logic d,
                             input jsu_pkg::err_t e, input logic l);
    utf8_result_t r;
    r.octet       = b;
    r.octet_valid = v;
    r.done        = d;
    r.err         = e;
    r.last        = l;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  task automatic push_octet(input logic [7:0] b);
    push_result(b, 1'b1, 1'b0, jsu_pkg::ERR_NONE, 1'b1);
  endtask

  // An error on a byte skips to the end marker; one caused by the marker goes idle
  task automatic push_error(input jsu_pkg::err_t e, input logic at_end);
    scan_state = at_end ? AWAIT_QUOTE : SKIP_TO_END;
    push_result(8'h00, 1'b0, 1'b0, e, 1'b1);
  endtask

  task automatic push_utf8(input logic [20:0] cp);
    logic [7:0] octets [4];
    int         n;
    if (cp < 21'h80) begin
      n = 1;
      octets[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      n = 2;
      octets[0] = 8'hC0 | cp[10:6];
      octets[1] = 8'h80 | cp[5:0];
    end else if (cp < 21'h10000) begin
      n = 3;
      octets[0] = 8'hE0 | cp[15:12];
      octets[1] = 8'h80 | cp[11:6];
      octets[2] = 8'h80 | cp[5:0];
    end else begin
      n = 4;
      octets[0] = 8'hF0 | cp[20:18];
      octets[1] = 8'h80 | cp[17:12];
      octets[2] = 8'h80 | cp[11:6];
      octets[3] = 8'h80 | cp[5:0];
    end
    for (int k = 0; k < n; k++) begin
      push_result(octets[k], 1'b1, 1'b0, jsu_pkg::ERR_NONE, k == n - 1);
    end
  endtask

  // Advance the decoder by one text transfer and queue the results it causes
  task automatic decode_text_byte(input logic [7:0] c, input logic at_end);
    int          nib;
    logic [15:0] unit;
    case (scan_state)
      AWAIT_QUOTE: begin
        if (!at_end) begin
          if (c != jsu_pkg::CH_QUOTE) push_error(jsu_pkg::ERR_NO_QUOTE, 1'b0);
          else scan_state = IN_STRING;
        end
      end
      IN_STRING: begin
        if (at_end) begin
          push_error(jsu_pkg::ERR_UNCLOSED, 1'b1);
        end else if (c == jsu_pkg::CH_QUOTE) begin
          scan_state = AWAIT_QUOTE;
          push_result(8'h00, 1'b0, 1'b1, jsu_pkg::ERR_NONE, 1'b1);
        end else if (c < jsu_pkg::CTRL_LIMIT) begin
          push_error(jsu_pkg::ERR_CONTROL, 1'b0);
        end else if (c == jsu_pkg::CH_BACKSLASH) begin
          scan_state = AFTER_BACKSLASH;
        end else begin
          push_octet(c);
        end
      end
      AFTER_BACKSLASH: begin
        if (at_end) begin
          push_error(jsu_pkg::ERR_ESC_END, 1'b1);
        end else begin
          scan_state = IN_STRING;
          case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: push_octet(c);
            jsu_pkg::CH_LOWER_B: push_octet(BACKSPACE);
            jsu_pkg::CH_LOWER_F: push_octet(FORM_FEED);
            jsu_pkg::CH_LOWER_N: push_octet(LINE_FEED);
            jsu_pkg::CH_LOWER_R: push_octet(CARRIAGE_RET);
            jsu_pkg::CH_LOWER_T: push_octet(HTAB);
            jsu_pkg::CH_LOWER_U: begin
              scan_state  = UNIT_HEX;
              unit_accum  = '0;
              digit_count = '0;
            end
            default: push_error(jsu_pkg::ERR_BAD_ESCAPE, 1'b0);
          endcase
        end
      end
      UNIT_HEX, LOW_HEX: begin
        nib = hex_nibble(c);
        if (at_end) begin
          push_error(jsu_pkg::ERR_HEX_CUT, 1'b1);
        end else if (nib < 0) begin
          push_error(jsu_pkg::ERR_NON_HEX, 1'b0);
        end else begin
          unit_accum = {unit_accum[11:0], nib[3:0]};
          if (digit_count != 2'd3) begin
            digit_count = digit_count + 2'd1;
          end else begin
            digit_count = '0;
            unit = unit_accum;
            if (scan_state == UNIT_HEX) begin
              // hold a high surrogate until its partner arrives
              if (unit >= jsu_pkg::HIGH_SURR_MIN && unit <= jsu_pkg::HIGH_SURR_MAX) begin
                high_bits  = unit[9:0];
                scan_state = PAIR_BACKSLASH;
              end else if (unit >= jsu_pkg::LOW_SURR_MIN && unit <= jsu_pkg::LOW_SURR_MAX) begin
                push_error(jsu_pkg::ERR_LONE_LOW, 1'b0);
              end else begin
                scan_state = IN_STRING;
                push_utf8({5'd0, unit});
              end
            end else if (unit < jsu_pkg::LOW_SURR_MIN || unit > jsu_pkg::LOW_SURR_MAX) begin
              push_error(jsu_pkg::ERR_BAD_LOW, 1'b0);
            end else begin
              scan_state = IN_STRING;
              push_utf8(21'h10000 + {1'b0, high_bits, unit[9:0]});
            end
          end
        end
      end
      PAIR_BACKSLASH: begin
        if (at_end) push_error(jsu_pkg::ERR_NO_LOW, 1'b1);
        else if (c != jsu_pkg::CH_BACKSLASH) push_error(jsu_pkg::ERR_NO_LOW, 1'b0);
        else scan_state = PAIR_U;
      end
      PAIR_U: begin
        if (at_end) begin
          push_error(jsu_pkg::ERR_NO_LOW, 1'b1);
        end else if (c != jsu_pkg::CH_LOWER_U) begin
          push_error(jsu_pkg::ERR_NO_LOW, 1'b0);
        end else begin
          scan_state  = LOW_HEX;
          unit_accum  = '0;
          digit_count = '0;
        end
      end
      default: begin
        if (at_end) scan_state = AWAIT_QUOTE;
      end
    endcase
  endtask

  // Predict on text transfers, compare on result transfers
  always @(posedge clk) begin
    utf8_result_t want;
    logic         bad;
    if (rst) begin
      scan_state  = AWAIT_QUOTE;
      unit_accum  = '0;
      digit_count = '0;
      high_bits   = '0;
      decoded_q.delete();
    end else begin
      if (text_valid && !text_stall) decode_text_byte(text_byte, text_end);
      if (res_valid && !res_stall) begin
        if (decoded_q.size() == 0) begin
          miss_total++;
          if (miss_total <= REPORT_LIMIT)
            $display("%0t: unexpected result byte %02h valid %0b done %0b err %0d last %0b",
                     $time, out_byte, out_valid, string_done, error_code, last);
        end else begin
          want = decoded_q.pop_front();
          bad = (out_byte !== want.octet) || (out_valid !== want.octet_valid) ||
                (string_done !== want.done) || (error_code !== want.err) ||
                (last !== want.last);
          if (bad) begin
            miss_total++;
            if (miss_total <= REPORT_LIMIT) begin
              $display("%0t: expected byte %02h valid %0b done %0b err %0d last %0b",
                       $time, want.octet, want.octet_valid, want.done, want.err,
                       want.last);
              $display("%0t:   actual byte %02h valid %0b done %0b err %0d last %0b",
                       $time, out_byte, out_valid, string_done, error_code, last);
            end
          end
        end
      end
    end
    pending_n = decoded_q.size();
  end

endmodule

// ----- tb/json_string_unescape_utf8_top_tb.sv -----
module json_string_unescape_utf8_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES    = 20;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
  } text_unit_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       text_valid = 1'b0;
  logic [7:0] text_byte = 8'h00;
  logic       text_end = 1'b0;
  logic       res_stall = 1'b0;
  logic       text_stall;
  logic       res_valid;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       string_done;
  logic [3:0] error_code;
  logic       last;
  int         mismatch_count;
  int         results_outstanding;

  text_unit_t text_q[$];
  bit         send_fast = 1'b0;
  bit         take_fast = 1'b0;
  bit         hold_off_req = 1'b0;
  int         cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  json_string_unescape_utf8_top u_top (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_byte  (text_byte),
    .text_end   (text_end),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_byte   (out_byte),
    .out_valid  (out_valid),
    .string_done(string_done),
    .error_code (error_code),
    .last       (last)
  );

  json_string_unescape_utf8_top_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .text_valid         (text_valid),
    .text_stall         (text_stall),
    .text_byte          (text_byte),
    .text_end           (text_end),
    .res_valid          (res_valid),
    .res_stall          (res_stall),
    .out_byte           (out_byte),
    .out_valid          (out_valid),
    .string_done        (string_done),
    .error_code         (error_code),
    .last               (last),
    .mismatch_count     (mismatch_count),
    .results_outstanding(results_outstanding)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL json_string_unescape_utf8_top");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'(int'("0") + n);
    if ($urandom_range(0, 1) == 0) return 8'(int'("a") + n - 10);
    return 8'(int'("A") + n - 10);
  endfunction

  function automatic logic [7:0] escape_letter();
    case ($urandom_range(0, 7))
      0: return jsu_pkg::CH_QUOTE;
      1: return jsu_pkg::CH_BACKSLASH;
      2: return jsu_pkg::CH_SLASH;
      3: return jsu_pkg::CH_LOWER_B;
      4: return jsu_pkg::CH_LOWER_F;
      5: return jsu_pkg::CH_LOWER_N;
      6: return jsu_pkg::CH_LOWER_R;
      default: return jsu_pkg::CH_LOWER_T;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), {b, 1'b0});
  endtask

  // End marker; its byte is don't-care, so vary it
  task automatic add_end();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    text_q.insert(text_q.size(), {b, 1'b1});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_unit(input logic [15:0] u);
    add_byte(jsu_pkg::CH_BACKSLASH);
    add_byte(jsu_pkg::CH_LOWER_U);
    for (int k = 0; k < 4; k++) add_byte(hex_char(u[15 - 4 * k -: 4]));
  endtask

  task automatic add_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(32, 255));
    while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BACKSLASH);
    add_byte(b);
  endtask

  // One string, mostly well formed; some are corrupted or cut short
  task automatic add_random_string();
    int          start_idx;
    int          segs;
    int          cut;
    logic [15:0] u;
    text_unit_t  t;
    start_idx = text_q.size();
    add_byte(jsu_pkg::CH_QUOTE);
    segs = ($urandom_range(0, 7) == 0) ? int'($urandom_range(8, 20)) :
                                         int'($urandom_range(0, 6));
    repeat (segs) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_plain();
        4, 9: begin
          add_byte(jsu_pkg::CH_BACKSLASH);
          add_byte(escape_letter());
        end
        5, 6: begin
          case ($urandom_range(0, 3))
            0: u = 16'($urandom_range(16'h0080, 16'h07FF));
            1: u = 16'($urandom_range(16'h0800, 16'hD7FF));
            2: u = 16'($urandom_range(16'hE000, 16'hFFFF));
            default: u = 16'($urandom_range(16'h0000, 16'h007F));
          endcase
          add_unit(u);
        end
        7: begin
          add_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
          add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
        default: add_unit(16'($urandom_range(16'h0000, 16'h007F)));
      endcase
    end
    add_byte(jsu_pkg::CH_QUOTE);
    case ($urandom_range(0, 9))
      0, 1: begin
        // overwrite one byte with noise
        cut = int'($urandom_range(start_idx, text_q.size() - 1));
        t = text_q[cut];
        t.b = 8'($urandom_range(0, 255));
        text_q[cut] = t;
        add_end();
      end
      2: begin
        // cut the text short
        cut = int'($urandom_range(start_idx + 1, text_q.size() - 1));
        while (text_q.size() > cut) void'(text_q.pop_back());
        add_end();
      end
      3: add_end();
      default: ;
    endcase
  endtask

  // Offer one transfer after a random gap and hold it until taken
  task automatic send_text(input text_unit_t t);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= t.b;
    text_end   <= t.e;
    @(posedge clk);
    while (text_stall) @(posedge clk);
  endtask

  task automatic flush_text();
    while (text_q.size() != 0) send_text(text_q.pop_front());
  endtask

  // Result side: random stalls, bursts without stalls, one long hold-off
  initial begin
    int hold;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_stall <= 1'b1;
        for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge clk);
      end
      hold = take_fast ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      if ($urandom_range(0, 15) == 0) take_fast = !take_fast;
    end
  end

  initial begin
    int sent;
    int drain;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // end marker while awaiting a quote, then an empty string
    add_end();
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(jsu_pkg::CH_QUOTE);
    // plain bytes at the edges of the allowed range
    add_byte(jsu_pkg::CH_QUOTE);
    add_text("A~");
    add_byte(jsu_pkg::CTRL_LIMIT);
    add_byte(8'h7F);
    add_byte(8'h80);
    add_byte(8'hFF);
    add_byte(jsu_pkg::CH_QUOTE);
    // every single-letter escape
    add_byte(jsu_pkg::CH_QUOTE);
    add_text("\\\"\\\\\\/\\b\\f\\n\\r\\t");
    add_byte(jsu_pkg::CH_QUOTE);
    flush_text();

    // fill the block while the result side holds off
    hold_off_req = 1'b1;
    send_fast = 1'b1;
    // units at each UTF-8 length boundary and surrogate pairs at the range edges
    add_byte(jsu_pkg::CH_QUOTE);
    add_unit(16'h0000);
    add_unit(16'h007F);
    add_unit(16'h0080);
    add_unit(16'h07FF);
    add_unit(16'h0800);
    add_unit(16'hD7FF);
    add_unit(16'hE000);
    add_unit(16'hFFFF);
    add_unit(16'hD800);
    add_unit(16'hDC00);
    add_unit(16'hDBFF);
    add_unit(16'hDFFF);
    add_byte(jsu_pkg::CH_QUOTE);
    add_end();
    flush_text();
    send_fast = 1'b0;

    // missing opening quote; the rest is skipped up to the end marker
    add_text("x");
    add_byte(jsu_pkg::CH_QUOTE);
    add_text("a");
    add_end();
    // control characters
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(8'h00);
    add_text("zz");
    add_end();
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(8'h1F);
    add_end();
    // unknown escape letter, and text ending right after a backslash
    add_text("\"\\q");
    add_end();
    add_text("\"\\");
    add_end();
    // hex cut short, and a bad digit that wins over the coming end
    add_text("\"\\u12");
    add_end();
    add_text("\"\\u1G");
    add_end();
    add_text("\"\\u/");
    add_end();
    // high surrogate without a proper low partner
    add_byte(jsu_pkg::CH_QUOTE);
    add_unit(16'hD800);
    add_text("x");
    add_end();
    add_byte(jsu_pkg::CH_QUOTE);
    add_unit(16'hD800);
    add_text("\\x");
    add_end();
    add_byte(jsu_pkg::CH_QUOTE);
    add_unit(16'hDBFF);
    add_end();
    add_byte(jsu_pkg::CH_QUOTE);
    add_unit(16'hD800);
    add_byte(jsu_pkg::CH_BACKSLASH);
    add_end();
    add_byte(jsu_pkg::CH_QUOTE);
    add_unit(16'hD800);
    add_unit(16'h0041);
    add_end();
    // lone low surrogate
    add_byte(jsu_pkg::CH_QUOTE);
    add_unit(16'hDFFF);
    add_end();
    // unclosed string
    add_text("\"abc");
    add_end();
    flush_text();

    // random strings, with some noise between them
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      send_fast = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        add_end();
      end
      add_random_string();
      sent += text_q.size();
      flush_text();
    end
    text_valid <= 1'b0;

    // drain outstanding results, then settle
    @(posedge clk);
    drain = 0;
    while (results_outstanding != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("PASS json_string_unescape_utf8_top");
    end else begin
      $display("FAIL json_string_unescape_utf8_top");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/jsu_pkg.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8_top.sv
tb/json_string_unescape_utf8_top_checker.sv
tb/json_string_unescape_utf8_top_tb.sv
